// ===== rtl/fpdrem_pkg.sv =====
// ----------------------------------------------------------------------------
// fpdrem_pkg: shared types and constants for the binary64 remainder block
// Field masks, canonical NaN and the step unit's control struct.
// ----------------------------------------------------------------------------
package fpdrem_pkg;

	localparam logic [63:0] QNAN_BITS  = 64'h7FF8_0000_0000_0000;
	localparam logic [62:0] EXP_MAG    = 63'h7FF0_0000_0000_0000;
	localparam logic [52:0] HIDDEN_BIT = 53'h10_0000_0000_0000;

	// control from the sequencer to the shared reduce unit
	typedef struct packed {
		logic load;   // clear partial remainder
		logic dbl;    // double (shift in a bit) before reduce
	} step_ctl_t;

endpackage

// ===== rtl/fpdrem_step.sv =====
// ----------------------------------------------------------------------------
// fpdrem_step: shared reduce-and-double unit
// Holds the partial remainder; load clears it, else each cycle it optionally
// doubles it shifting in one bit, then subtracts the divisor significand
// once if it fits (one compare/subtract), so the remainder stays below it.
// ----------------------------------------------------------------------------
module fpdrem_step
	import fpdrem_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  step_ctl_t   ctl,
	input  logic        shin,
	input  logic [52:0] my,
	output logic [53:0] rem
);

	logic [53:0] rem_q;
	logic [53:0] base;
	logic [54:0] diff;

	always_comb begin
		base = ctl.dbl ? {rem_q[52:0], shin} : rem_q;
		diff = {1'b0, base} - {2'b00, my};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (ctl.load) begin
			rem_q <= '0;
		end else begin
			rem_q <= diff[54] ? base : diff[53:0];
		end
	end

	assign rem = rem_q;

endmodule

// ===== rtl/fp_double_remainder.sv =====
// ----------------------------------------------------------------------------
// fp_double_remainder: binary64 truncated remainder (fmod)
// Iterative shift-and-subtract over integer significands.
// ----------------------------------------------------------------------------
// One word at a time. After a word is accepted the block decodes special
// cases (NaN, zero divisor, infinite dividend, |x|<=|y|) in DECODE. Else
// it reduces the dividend significand modulo the divisor's with one
// double-and-reduce step per bit: first the 53 dividend significand bits
// MSB first (any divisor, subnormal included), then one step per unit of
// exponent difference (up to 2045); then NORM picks up the remainder,
// normalize-shifts it while the exponent allows and packs it. Shift count
// and exponent difference together stay within 2045. The result sits in an
// output register; the input stalls while busy.
// ----------------------------------------------------------------------------
module fp_double_remainder
	import fpdrem_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] dividend_bits,
	input  logic [63:0] divisor_bits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] remainder_bits,
	output logic        invalid_flag
);

	typedef enum logic [2:0] {IDLE, DECODE, LOOP, NORM, DONE} state_t;

	state_t      state_q;
	logic [63:0] x_q, y_q;
	logic [52:0] my_q;
	logic [52:0] mx_q;    // dividend significand, fed in MSB first
	logic [11:0] cnt_q;   // remaining reduce steps
	logic [10:0] ey_q;
	logic [53:0] r_q;     // normalize shifter
	logic [63:0] res_q;
	logic        inv_q;

	step_ctl_t   ctl;
	logic [53:0] rem;
	logic        shin;

	// operand decode (combinational, from held operands)
	logic [62:0] ax, ay;
	logic [10:0] ex_f, ey_f, ex, ey;
	logic [52:0] mx, my;
	logic        bad;
	always_comb begin
		ax   = x_q[62:0];
		ay   = y_q[62:0];
		ex_f = ax[62:52];
		ey_f = ay[62:52];
		ex   = (ex_f == '0) ? 11'd1 : ex_f;
		ey   = (ey_f == '0) ? 11'd1 : ey_f;
		mx   = {(ex_f != '0), ax[51:0]};
		my   = {(ey_f != '0), ay[51:0]};
		bad  = (ay == '0) || (ax > EXP_MAG) || (ay > EXP_MAG) || (ax == EXP_MAG);
	end

	assign shin = mx_q[52];
	always_comb begin
		ctl.load = (state_q == DECODE);
		ctl.dbl  = (state_q == LOOP);
	end

	fpdrem_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.shin   (shin),
		.my     (my_q),
		.rem    (rem)
	);

	assign in_stall       = (state_q != IDLE);
	assign out_valid      = (state_q == DONE);
	assign remainder_bits = res_q;
	assign invalid_flag   = inv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			x_q     <= '0;
			y_q     <= '0;
			my_q    <= '0;
			mx_q    <= '0;
			cnt_q   <= '0;
			ey_q    <= '0;
			r_q     <= '0;
			res_q   <= '0;
			inv_q   <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						x_q     <= dividend_bits;
						y_q     <= divisor_bits;
						state_q <= DECODE;
					end
				end
				DECODE: begin
					my_q  <= my;
					mx_q  <= mx;
					ey_q  <= ey;
					// 53 dividend bits, then one step per exponent unit
					cnt_q <= {1'b0, ex} - {1'b0, ey} + 12'd53;
					inv_q <= 1'b0;
					if (bad) begin
						res_q   <= QNAN_BITS;
						inv_q   <= 1'b1;
						state_q <= DONE;
					end else if (ax < ay) begin
						res_q   <= x_q;
						state_q <= DONE;
					end else if (ax == ay) begin
						res_q   <= {x_q[63], 63'd0};
						state_q <= DONE;
					end else begin
						state_q <= LOOP;
					end
				end
				LOOP: begin
					// unit doubles, shifts in the next dividend bit, reduces
					mx_q <= {mx_q[51:0], 1'b0};
					if (cnt_q == 12'd1) begin
						state_q <= NORM;
						r_q     <= 54'd0;
					end
					cnt_q <= cnt_q - 12'd1;
				end
				NORM: begin
					// first NORM cycle after LOOP picks up the final remainder
					if (r_q == '0 && rem != '0 && cnt_q == '0) begin
						r_q   <= rem;
						cnt_q <= 12'hFFF;
					end else if (r_q == '0) begin
						res_q   <= {x_q[63], 63'd0};
						state_q <= DONE;
					end else if (!r_q[52] && ey_q > 11'd1) begin
						r_q  <= {r_q[52:0], 1'b0};
						ey_q <= ey_q - 11'd1;
					end else if (r_q[52]) begin
						res_q   <= {x_q[63], ey_q, r_q[51:0]};
						state_q <= DONE;
					end else begin
						res_q   <= {x_q[63], 11'd0, r_q[51:0]};
						state_q <= DONE;
					end
				end
				DONE: begin
					if (!out_stall) state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule
